FILE: rtl/rsq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsq_pkg
// Shared types, constants and functions of the rotated sprite quad expander.
// ---------------------------------------------------------------------------
package rsq_pkg;

	// quarter-wave sine table size, log2 of entries (range 6..14)
	localparam int SINE_TABLE_BITS_DEF = 10;

	// corner coordinate width (signed) and sine/cosine width (signed Q1.16)
	localparam int CW = 38;
	localparam int SW = 18;
	localparam int Q_FRAC = 16;

	localparam logic [16:0] CAP_MAX = 17'd65536;
	localparam logic [2:0]  LAST_VTX = 3'd5;
	localparam logic [1:0]  ROT_LAST = 2'd3;

	// configuration port
	localparam int APB_AW = 3;
	localparam logic [APB_AW-1:0] REG_VERTEX_CAPACITY = 3'd0;

	// pi/2 in Q30 and Taylor denominators (2n)(2n+1)
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	typedef struct packed {
		logic        restart;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] width;
		logic [31:0] height;
		logic [16:0] origin_x;
		logic [16:0] origin_y;
		logic [15:0] angle;
		logic [63:0] uv_region;
		logic [1:0]  flips;
		logic [31:0] tint;
	} rsq_sprite_t;

	typedef struct packed {
		logic [15:0] slot;
		logic [31:0] vert_x;
		logic [31:0] vert_y;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [31:0] color;
		logic        last;
	} rsq_vertex_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       setup;
		logic       corner;
		logic       rot;
		logic [1:0] rot_idx;
		logic       finish;
		logic       emit;
		logic [2:0] vtx;
	} rsq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fits;
		logic rotate;
		logic out_free;
	} rsq_sts_t;

	// one quarter-wave entry, Q16 with 1.0 = 65536
	function automatic logic [16:0] quarter_entry(input int unsigned k, input int unsigned bits);
		logic [63:0] xr;
		logic [63:0] sum;
		logic [63:0] term;
		int          n;
		if (k >= (32'd1 << bits)) begin
			return CAP_MAX;
		end
		xr = (64'(k) * HALF_PI_Q30) >> bits;
		sum = xr;
		term = xr;
		for (n = 1; n <= 6; n++) begin
			term = (term * xr) >> 30;
			term = (term * xr) >> 30;
			term = term / TAYLOR_DIV[n-1];
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		sum = (sum + 64'd8192) >> 14;
		if (sum > 64'd65536) begin
			sum = 64'd65536;
		end
		return sum[16:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [CW:0] v);
		logic signed [CW:0] hi;
		logic signed [CW:0] lo;
		hi = $signed((CW+1)'(32'h7FFF_FFFF));
		lo = ~hi;
		if (v > hi) begin
			return 32'h7FFF_FFFF;
		end else if (v < lo) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// triangle list order: corners 1,2,3,1,3,4
	function automatic logic [1:0] corner_of(input logic [2:0] vtx);
		logic [1:0] c;
		case (vtx)
			3'd0: c = 2'd0;
			3'd1: c = 2'd1;
			3'd2: c = 2'd2;
			3'd3: c = 2'd0;
			3'd4: c = 2'd2;
			3'd5: c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/rsq_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsq_if
// Sprite input channel and vertex output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface rsq_sprite_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] width;
	logic [31:0] height;
	logic [16:0] origin_x;
	logic [16:0] origin_y;
	logic [15:0] angle;
	logic [63:0] uv_region;
	logic [1:0]  flips;
	logic [31:0] tint;

	modport source (
		output valid, restart, pos_x, pos_y, width, height, origin_x, origin_y,
		       angle, uv_region, flips, tint,
		input  ready
	);
	modport sink (
		input  valid, restart, pos_x, pos_y, width, height, origin_x, origin_y,
		       angle, uv_region, flips, tint,
		output ready
	);
endinterface

interface rsq_vertex_if;
	logic        valid;
	logic        ready;
	logic [15:0] slot;
	logic [31:0] vert_x;
	logic [31:0] vert_y;
	logic [15:0] tex_u;
	logic [15:0] tex_v;
	logic [31:0] color;
	logic        last;

	modport source (
		output valid, slot, vert_x, vert_y, tex_u, tex_v, color, last,
		input  ready
	);
	modport sink (
		input  valid, slot, vert_x, vert_y, tex_u, tex_v, color, last,
		output ready
	);
endinterface

FILE: rtl/rotated_sprite_quad_expander.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotated_sprite_quad_expander
// Expands one sprite into two triangles (six vertices) with buffer slots.
// ---------------------------------------------------------------------------
// One sprite is handled at a time: a new sprite is accepted only after the
// current one has been emitted or dropped for lack of room. The controller
// sequence is a setup step (two 32x17 multipliers for the pivot, registered
// read of the quarter-wave sine ROM), a corner step, a pass of the shared
// four-multiplier rotation unit over three corners and a completion step for
// the fourth, then one vertex per cycle through the single output register
// while the vertex channel is not stalled. Rotation and completion are skipped
// when the angle is zero. The vertex count restarts when restart is set
// on a sprite; a sprite is written only if all six slots fit below
// vertex_capacity (APB byte address 0, capped at 65536). The sine ROM holds
// 2^SINE_TABLE_BITS+1 entries.
module rotated_sprite_quad_expander #(
	parameter int SINE_TABLE_BITS = rsq_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rsq_sprite_if.sink                 sprite,
	rsq_vertex_if.source               vertex,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rsq_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [16:0]          cap_q;
	rsq_pkg::rsq_cmd_t    cmd;
	rsq_pkg::rsq_sts_t    sts;
	rsq_pkg::rsq_sprite_t sprite_item;
	rsq_pkg::rsq_vertex_t vertex_item;
	logic                 in_ready;
	logic                 vout_valid;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= rsq_pkg::CAP_MAX;
		end else if (psel && penable && pwrite && pready &&
		             paddr == rsq_pkg::REG_VERTEX_CAPACITY) begin
			cap_q <= pwdata[16:0];
		end
	end

	assign prdata = (paddr == rsq_pkg::REG_VERTEX_CAPACITY) ? {15'd0, cap_q} : 32'd0;

	always_comb begin
		sprite_item.restart   = sprite.restart;
		sprite_item.pos_x     = sprite.pos_x;
		sprite_item.pos_y     = sprite.pos_y;
		sprite_item.width     = sprite.width;
		sprite_item.height    = sprite.height;
		sprite_item.origin_x  = sprite.origin_x;
		sprite_item.origin_y  = sprite.origin_y;
		sprite_item.angle     = sprite.angle;
		sprite_item.uv_region = sprite.uv_region;
		sprite_item.flips     = sprite.flips;
		sprite_item.tint      = sprite.tint;
	end

	assign sprite.ready  = in_ready;
	assign vertex.valid  = vout_valid;
	assign vertex.slot   = vertex_item.slot;
	assign vertex.vert_x = vertex_item.vert_x;
	assign vertex.vert_y = vertex_item.vert_y;
	assign vertex.tex_u  = vertex_item.tex_u;
	assign vertex.tex_v  = vertex_item.tex_v;
	assign vertex.color  = vertex_item.color;
	assign vertex.last   = vertex_item.last;

	rsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sprite.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsq_datapath #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cap        (cap_q),
		.sprite_in  (sprite_item),
		.vout_valid (vout_valid),
		.vout_ready (vertex.ready),
		.vout       (vertex_item)
	);

endmodule

FILE: rtl/rsq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsq_ctrl
// Sequencer: accept, setup, corners, rotation pass, completion, emission.
// ---------------------------------------------------------------------------
module rsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rsq_pkg::rsq_sts_t sts,
	output rsq_pkg::rsq_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CORNER,
		ST_ROT,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					// sprite dropped whole when six slots are not free
					state_q <= sts.fits ? ST_CORNER : ST_IDLE;
				end
				ST_CORNER: begin
					cnt_q   <= '0;
					state_q <= sts.rotate ? ST_ROT : ST_EMIT;
				end
				ST_ROT: begin
					if (cnt_q[1:0] == rsq_pkg::ROT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_FINISH: begin
					cnt_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (cnt_q == rsq_pkg::LAST_VTX) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.load    = in_valid && (state_q == ST_IDLE);
		cmd.setup   = (state_q == ST_SETUP);
		cmd.corner  = (state_q == ST_CORNER);
		cmd.rot     = (state_q == ST_ROT);
		cmd.rot_idx = cnt_q[1:0];
		cmd.finish  = (state_q == ST_FINISH);
		cmd.emit    = (state_q == ST_EMIT) && sts.out_free;
		cmd.vtx     = cnt_q;
	end

	a_drop_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) && !sts.fits |=> state_q == ST_IDLE)
		else $error("dropped sprite did not return to idle");

	a_load_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SETUP && !cmd.emit)
		else $error("accepted item not followed by setup");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> cnt_q <= rsq_pkg::LAST_VTX)
		else $error("vertex index beyond sixth vertex");

endmodule

FILE: rtl/rsq_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsq_datapath
// Sprite registers, sine ROM, corner multipliers, rotation unit, slot count
// and the vertex output register.
// ---------------------------------------------------------------------------
module rsq_datapath #(
	parameter int SINE_TABLE_BITS = rsq_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsq_pkg::rsq_cmd_t    cmd,
	output rsq_pkg::rsq_sts_t    sts,
	input  logic [16:0]          cap,
	input  rsq_pkg::rsq_sprite_t sprite_in,
	output logic                 vout_valid,
	input  logic                 vout_ready,
	output rsq_pkg::rsq_vertex_t vout
);

	localparam int CW = rsq_pkg::CW;
	localparam int SW = rsq_pkg::SW;
	localparam int PW = CW + SW;
	localparam int QN = 1 << SINE_TABLE_BITS;
	localparam int IW = SINE_TABLE_BITS + 1;

	typedef logic [16:0] rom_t [QN+1];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k <= QN; k++) begin
			r[k] = rsq_pkg::quarter_entry(k, SINE_TABLE_BITS);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// latched sprite
	logic signed [31:0] pos_x_q, pos_y_q, width_q, height_q;
	logic [16:0]        origin_x_q, origin_y_q;
	logic [15:0]        angle_q;
	logic [15:0]        u1_q, u2_q, v1_q, v2_q;
	logic [31:0]        tint_q;
	logic [16:0]        count_q;

	// setup / corners / rotation
	logic signed [49:0]   mcx, mcy;
	logic signed [CW-1:0] cx_q, cy_q;
	logic [16:0]          rom_s_q, rom_c_q;
	logic signed [SW-1:0] s_q, c_q;
	logic signed [CW-1:0] corner_x_q [4];
	logic signed [CW-1:0] corner_y_q [4];
	logic signed [PW-1:0] pca_q, psb_q, psa_q, pcb_q;
	logic signed [PW:0]   rx_sum, ry_sum;
	logic signed [CW-1:0] rot_x, rot_y;
	logic signed [CW-1:0] w_ext, h_ext;

	logic [1:0]             quad;
	logic [SINE_TABLE_BITS-1:0] ang_i;
	logic [IW-1:0]          idx_s, idx_c;
	logic [16:0]            cap_eff;

	// emission
	logic [1:0]           csel;
	logic signed [CW-1:0] sel_x, sel_y;
	logic signed [CW:0]   sum_x, sum_y;
	rsq_pkg::rsq_vertex_t vout_q;
	logic                 vout_valid_q;

	always_comb begin
		quad  = angle_q[15:14];
		ang_i = angle_q[13 -: SINE_TABLE_BITS];
		// cos(a) = sin(a + quarter turn): mirrored index in the other quadrants
		idx_s = quad[0] ? IW'(QN) - IW'(ang_i) : IW'(ang_i);
		idx_c = quad[0] ? IW'(ang_i) : IW'(QN) - IW'(ang_i);

		mcx = 50'($signed(width_q)) * 50'($signed({1'b0, origin_x_q}));
		mcy = 50'($signed(height_q)) * 50'($signed({1'b0, origin_y_q}));

		w_ext = CW'($signed(width_q));
		h_ext = CW'($signed(height_q));

		rx_sum = (PW+1)'(pca_q) - (PW+1)'(psb_q);
		ry_sum = (PW+1)'(psa_q) + (PW+1)'(pcb_q);
		rot_x  = CW'(rx_sum >>> rsq_pkg::Q_FRAC);
		rot_y  = CW'(ry_sum >>> rsq_pkg::Q_FRAC);

		cap_eff = (cap > rsq_pkg::CAP_MAX) ? rsq_pkg::CAP_MAX : cap;

		csel  = rsq_pkg::corner_of(cmd.vtx);
		sel_x = corner_x_q[csel];
		sel_y = corner_y_q[csel];
		sum_x = (CW+1)'(sel_x) + (CW+1)'($signed(pos_x_q));
		sum_y = (CW+1)'(sel_y) + (CW+1)'($signed(pos_y_q));

		sts.fits     = ({1'b0, count_q} + 18'd6) <= {1'b0, cap_eff};
		sts.rotate   = (angle_q != 16'd0);
		sts.out_free = !vout_valid_q || vout_ready;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_x_q    <= sprite_in.pos_x;
			pos_y_q    <= sprite_in.pos_y;
			width_q    <= sprite_in.width;
			height_q   <= sprite_in.height;
			origin_x_q <= sprite_in.origin_x;
			origin_y_q <= sprite_in.origin_y;
			angle_q    <= sprite_in.angle;
			tint_q     <= sprite_in.tint;
			u1_q <= sprite_in.flips[0] ? sprite_in.uv_region[47:32] : sprite_in.uv_region[15:0];
			u2_q <= sprite_in.flips[0] ? sprite_in.uv_region[15:0] : sprite_in.uv_region[47:32];
			v1_q <= sprite_in.flips[1] ? sprite_in.uv_region[63:48] : sprite_in.uv_region[31:16];
			v2_q <= sprite_in.flips[1] ? sprite_in.uv_region[31:16] : sprite_in.uv_region[63:48];
		end

		if (cmd.setup) begin
			cx_q    <= CW'($signed(mcx[49:16]));
			cy_q    <= CW'($signed(mcy[49:16]));
			rom_s_q <= SINE_ROM[idx_s];
			rom_c_q <= SINE_ROM[idx_c];
		end

		if (cmd.corner) begin
			corner_x_q[0] <= -cx_q;
			corner_y_q[0] <= -cy_q;
			corner_x_q[1] <= -cx_q;
			corner_y_q[1] <= h_ext - cy_q;
			corner_x_q[2] <= w_ext - cx_q;
			corner_y_q[2] <= h_ext - cy_q;
			corner_x_q[3] <= w_ext - cx_q;
			corner_y_q[3] <= -cy_q;
			s_q <= quad[1] ? -$signed({1'b0, rom_s_q}) : $signed({1'b0, rom_s_q});
			c_q <= (quad[1] ^ quad[0]) ? -$signed({1'b0, rom_c_q}) : $signed({1'b0, rom_c_q});
		end

		// corners 0..2 circulate: products taken from slot 0, results enter slot 2
		if (cmd.rot) begin
			if (cmd.rot_idx != rsq_pkg::ROT_LAST) begin
				pca_q <= PW'(c_q) * PW'(corner_x_q[0]);
				psb_q <= PW'(s_q) * PW'(corner_y_q[0]);
				psa_q <= PW'(s_q) * PW'(corner_x_q[0]);
				pcb_q <= PW'(c_q) * PW'(corner_y_q[0]);
			end
			corner_x_q[0] <= corner_x_q[1];
			corner_y_q[0] <= corner_y_q[1];
			corner_x_q[1] <= corner_x_q[2];
			corner_y_q[1] <= corner_y_q[2];
			if (cmd.rot_idx == 2'd0) begin
				corner_x_q[2] <= corner_x_q[0];
				corner_y_q[2] <= corner_y_q[0];
			end else begin
				corner_x_q[2] <= rot_x;
				corner_y_q[2] <= rot_y;
			end
		end

		// fourth corner completes the parallelogram
		if (cmd.finish) begin
			corner_x_q[3] <= corner_x_q[0] + (corner_x_q[2] - corner_x_q[1]);
			corner_y_q[3] <= corner_y_q[2] - (corner_y_q[1] - corner_y_q[0]);
		end

		if (cmd.emit) begin
			vout_q.slot   <= count_q[15:0] + 16'(cmd.vtx);
			vout_q.vert_x <= rsq_pkg::sat32(sum_x);
			vout_q.vert_y <= rsq_pkg::sat32(sum_y);
			vout_q.tex_u  <= (csel == 2'd0 || csel == 2'd1) ? u1_q : u2_q;
			vout_q.tex_v  <= (csel == 2'd0 || csel == 2'd3) ? v1_q : v2_q;
			vout_q.color  <= tint_q;
			vout_q.last   <= (cmd.vtx == rsq_pkg::LAST_VTX);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			vout_valid_q <= 1'b0;
		end else begin
			if (cmd.load && sprite_in.restart) begin
				count_q <= '0;
			end else if (cmd.emit && cmd.vtx == rsq_pkg::LAST_VTX) begin
				count_q <= count_q + 17'd6;
			end

			if (cmd.emit) begin
				vout_valid_q <= 1'b1;
			end else if (vout_ready) begin
				vout_valid_q <= 1'b0;
			end
		end
	end

	assign vout_valid = vout_valid_q;
	assign vout       = vout_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rsq_pkg::CAP_MAX)
		else $error("vertex count above buffer limit");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && sprite_in.restart |=> count_q == 17'd0)
		else $error("restart did not clear vertex count");

	a_commit_six: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.vtx == rsq_pkg::LAST_VTX |=> count_q == $past(count_q) + 17'd6)
		else $error("vertex count not advanced by six after last vertex");

endmodule

FILE: sim/rsq_vertex_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsq_vertex_checker
// Watches the sprite, vertex and register ports of the quad expander, works
// out the six vertices of every accepted sprite that fits and compares them in order.
// ---------------------------------------------------------------------------
module rsq_vertex_checker #(
	parameter int SINE_BITS = rsq_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rsq_sprite_if                      spr,
	rsq_vertex_if                      vtx,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rsq_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic [31:0]                prdata,
	input  logic                       pready,
	output int                         fails,
	output int                         pending
);

	localparam int QSIZE = 1 << SINE_BITS;
	localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [16:0] CAPACITY_RESET = 17'd65536;
	localparam int CORNER_SEQ [6] = '{0, 1, 2, 0, 2, 3};

	longint               quarter_sine [QSIZE+1];
	int unsigned          vcount;
	logic [16:0]          capacity;
	rsq_pkg::rsq_vertex_t vertex_q [$];
	rsq_pkg::rsq_sprite_t seen_sprite;
	rsq_pkg::rsq_vertex_t seen_vertex;
	rsq_pkg::rsq_vertex_t want;
	int                   n_fail;

	function automatic longint taylor_q16(input int unsigned k);
		logic [63:0] x;
		logic [63:0] acc;
		logic [63:0] t;
		int          n;
		if (k >= QSIZE) begin
			return 65536;
		end
		x = (64'(k) * QUARTER_TURN_Q30) >> SINE_BITS;
		acc = x;
		t = x;
		for (n = 1; n <= 6; n++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / 64'((2 * n) * (2 * n + 1));
			acc = (n % 2 == 1) ? acc - t : acc + t;
		end
		acc = (acc + 64'd8192) >> 14;
		if (acc > 64'd65536) begin
			acc = 64'd65536;
		end
		return longint'(acc);
	endfunction

	function automatic longint sine_of(input logic [15:0] a);
		int unsigned idx;
		longint      v;
		idx = a[13:0] >> (14 - SINE_BITS);
		v = a[14] ? quarter_sine[QSIZE - idx] : quarter_sine[idx];
		return a[15] ? -v : v;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	task automatic report(input string msg);
		n_fail++;
		$display("%0t: MISMATCH %s", $time, msg);
	endtask

	task automatic expand_sprite(input rsq_pkg::rsq_sprite_t s);
		longint               px, py, w, h, ox, oy, cx, cy, sn, cs, a, b;
		longint               xs [4];
		longint               ys [4];
		logic [15:0]          ua, ub, va, vb;
		logic [15:0]          us [4];
		logic [15:0]          vs [4];
		logic [15:0]          tmp;
		int unsigned          lim;
		int                   k;
		int                   c;
		rsq_pkg::rsq_vertex_t e;
		if (s.restart) begin
			vcount = 0;
		end
		lim = (capacity > rsq_pkg::CAP_MAX) ? 65536 : capacity;
		if (vcount + 6 > lim) begin
			return;
		end
		px = longint'($signed(s.pos_x));
		py = longint'($signed(s.pos_y));
		w = longint'($signed(s.width));
		h = longint'($signed(s.height));
		ox = longint'(s.origin_x);
		oy = longint'(s.origin_y);
		cx = (w * ox) >>> 16;
		cy = (h * oy) >>> 16;
		xs[0] = -cx;    ys[0] = -cy;
		xs[1] = -cx;    ys[1] = h - cy;
		xs[2] = w - cx; ys[2] = h - cy;
		xs[3] = w - cx; ys[3] = -cy;
		if (s.angle != 16'd0) begin
			sn = sine_of(s.angle);
			cs = sine_of(s.angle + 16'd16384);
			for (k = 0; k < 3; k++) begin
				a = xs[k];
				b = ys[k];
				xs[k] = (cs * a - sn * b) >>> 16;
				ys[k] = (sn * a + cs * b) >>> 16;
			end
			// fourth corner closes the parallelogram
			xs[3] = xs[0] + (xs[2] - xs[1]);
			ys[3] = ys[2] - (ys[1] - ys[0]);
		end
		ua = s.uv_region[15:0];
		va = s.uv_region[31:16];
		ub = s.uv_region[47:32];
		vb = s.uv_region[63:48];
		if (s.flips[0]) begin
			tmp = ua; ua = ub; ub = tmp;
		end
		if (s.flips[1]) begin
			tmp = va; va = vb; vb = tmp;
		end
		us[0] = ua; vs[0] = va;
		us[1] = ua; vs[1] = vb;
		us[2] = ub; vs[2] = vb;
		us[3] = ub; vs[3] = va;
		for (k = 0; k < 6; k++) begin
			c = CORNER_SEQ[k];
			e.slot = 16'(vcount + k);
			e.vert_x = clamp32(xs[c] + px);
			e.vert_y = clamp32(ys[c] + py);
			e.tex_u = us[c];
			e.tex_v = vs[c];
			e.color = s.tint;
			e.last = (k == 5);
			vertex_q.push_back(e);
		end
		vcount += 6;
	endtask

	initial begin
		n_fail = 0;
		for (int k = 0; k <= QSIZE; k++) begin
			quarter_sine[k] = taylor_q16(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount = 0;
			capacity = CAPACITY_RESET;
			vertex_q.delete();
		end else begin
			if (psel && penable && pready && paddr == rsq_pkg::REG_VERTEX_CAPACITY) begin
				if (pwrite) begin
					capacity = pwdata[16:0];
				end else if (prdata !== {15'd0, capacity}) begin
					report($sformatf("capacity read %0h, expected %0h", prdata, capacity));
				end
			end
			if (vtx.valid && vtx.ready) begin
				seen_vertex = '{slot: vtx.slot, vert_x: vtx.vert_x, vert_y: vtx.vert_y,
					tex_u: vtx.tex_u, tex_v: vtx.tex_v, color: vtx.color, last: vtx.last};
				if (vertex_q.size() == 0) begin
					report($sformatf("vertex at slot %0d with nothing outstanding",
						seen_vertex.slot));
				end else begin
					want = vertex_q.pop_front();
					if (seen_vertex.slot !== want.slot)
						report($sformatf("slot %0h, expected %0h", seen_vertex.slot, want.slot));
					if (seen_vertex.vert_x !== want.vert_x)
						report($sformatf("slot %0d vert_x %0h, expected %0h", want.slot,
							seen_vertex.vert_x, want.vert_x));
					if (seen_vertex.vert_y !== want.vert_y)
						report($sformatf("slot %0d vert_y %0h, expected %0h", want.slot,
							seen_vertex.vert_y, want.vert_y));
					if (seen_vertex.tex_u !== want.tex_u)
						report($sformatf("slot %0d tex_u %0h, expected %0h", want.slot,
							seen_vertex.tex_u, want.tex_u));
					if (seen_vertex.tex_v !== want.tex_v)
						report($sformatf("slot %0d tex_v %0h, expected %0h", want.slot,
							seen_vertex.tex_v, want.tex_v));
					if (seen_vertex.color !== want.color)
						report($sformatf("slot %0d color %0h, expected %0h", want.slot,
							seen_vertex.color, want.color));
					if (seen_vertex.last !== want.last)
						report($sformatf("slot %0d last %0b, expected %0b", want.slot,
							seen_vertex.last, want.last));
				end
			end
			if (spr.valid && spr.ready) begin
				seen_sprite = '{restart: spr.restart, pos_x: spr.pos_x, pos_y: spr.pos_y,
					width: spr.width, height: spr.height, origin_x: spr.origin_x,
					origin_y: spr.origin_y, angle: spr.angle, uv_region: spr.uv_region,
					flips: spr.flips, tint: spr.tint};
				expand_sprite(seen_sprite);
			end
		end
		fails <= n_fail;
		pending <= vertex_q.size();
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives sprites and capacity writes into the quad expander under varying
// back-pressure; the checker beside the block predicts and compares vertices.
// ---------------------------------------------------------------------------
module tb;

	localparam int SINE_BITS = rsq_pkg::SINE_TABLE_BITS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS = 24;
	// a few sprites with the register set above the slot ceiling
	localparam int CEIL_ITEMS = 5;
	localparam logic [15:0] DIR_ANGLES [6] = '{16'd1, 16'd8192, 16'd16384, 16'd32768,
		16'd49152, 16'd65535};

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [rsq_pkg::APB_AW-1:0]  paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;
	int                          chk_fails;
	int                          chk_pending;
	int                          send_idle_pct;
	int                          recv_stall_pct;
	int                          quiet_cycles;

	rsq_sprite_if spr ();
	rsq_vertex_if vtx ();

	rotated_sprite_quad_expander #(
		.SINE_TABLE_BITS(SINE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sprite  (spr),
		.vertex  (vtx),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rsq_vertex_checker #(
		.SINE_BITS(SINE_BITS)
	) chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.spr     (spr),
		.vtx     (vtx),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fails   (chk_fails),
		.pending (chk_pending)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		vtx.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (spr.valid && spr.ready) || (vtx.valid && vtx.ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("rotated_sprite_quad_expander test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [31:0] pick_q16();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			3: return -$urandom_range(0, 32'h0200_0000);
			default: return $urandom_range(0, 32'h0200_0000);
		endcase
	endfunction

	function automatic rsq_pkg::rsq_sprite_t rand_sprite(input int restart_pct);
		rsq_pkg::rsq_sprite_t s;
		s.restart = ($urandom_range(99) < restart_pct);
		s.pos_x = pick_q16();
		s.pos_y = pick_q16();
		s.width = pick_size();
		s.height = pick_size();
		case ($urandom_range(7))
			0: s.origin_x = 17'd0;
			1: s.origin_x = 17'd65536;
			2: s.origin_x = 17'($urandom_range(65537, 131071));
			default: s.origin_x = 17'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(7))
			0: s.origin_y = 17'd0;
			1: s.origin_y = 17'd65536;
			2: s.origin_y = 17'($urandom_range(65537, 131071));
			default: s.origin_y = 17'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(7))
			0: s.angle = 16'd0;
			1: s.angle = {2'($urandom_range(3)), 14'd0};
			default: s.angle = 16'($urandom_range(0, 65535));
		endcase
		s.uv_region = {$urandom, $urandom};
		s.flips = 2'($urandom_range(3));
		s.tint = $urandom;
		return s;
	endfunction

	task automatic send_sprite(input rsq_pkg::rsq_sprite_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			spr.valid <= 1'b0;
			@(posedge clk);
		end
		spr.valid <= 1'b1;
		spr.restart <= s.restart;
		spr.pos_x <= s.pos_x;
		spr.pos_y <= s.pos_y;
		spr.width <= s.width;
		spr.height <= s.height;
		spr.origin_x <= s.origin_x;
		spr.origin_y <= s.origin_y;
		spr.angle <= s.angle;
		spr.uv_region <= s.uv_region;
		spr.flips <= s.flips;
		spr.tint <= s.tint;
		@(posedge clk);
		while (!spr.ready) @(posedge clk);
	endtask

	// stop sending, let every vertex drain, then allow a dropped sprite to finish
	task automatic drain();
		spr.valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [rsq_pkg::APB_AW-1:0] a,
			input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_capacity(input logic [16:0] cap);
		apb_access(1'b1, rsq_pkg::REG_VERTEX_CAPACITY, {15'd0, cap});
		apb_access(1'b0, rsq_pkg::REG_VERTEX_CAPACITY, 32'd0);
	endtask

	task automatic random_phase(input int restart_pct);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			send_sprite(rand_sprite(restart_pct));
		end
	endtask

	initial begin
		rsq_pkg::rsq_sprite_t s;
		rsq_pkg::rsq_sprite_t base;
		arst_n = 1'b0;
		quiet_cycles = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		spr.valid = 1'b0;
		spr.restart = 1'b0;
		spr.pos_x = '0;
		spr.pos_y = '0;
		spr.width = '0;
		spr.height = '0;
		spr.origin_x = '0;
		spr.origin_y = '0;
		spr.angle = '0;
		spr.uv_region = '0;
		spr.flips = '0;
		spr.tint = '0;
		vtx.ready = 1'b0;
		send_idle_pct = 10;
		recv_stall_pct = 60;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_access(1'b0, rsq_pkg::REG_VERTEX_CAPACITY, 32'd0);

		base = '0;
		base.restart = 1'b1;
		base.width = 32'h0010_0000;
		base.height = 32'h0008_0000;
		base.origin_x = 17'd32768;
		base.origin_y = 17'd32768;
		base.uv_region = 64'hF000_C000_4000_1000;
		base.tint = 32'hFF80_4020;
		send_sprite(base);
		s = '0;
		send_sprite(s);
		s = '1;
		s.restart = 1'b0;
		send_sprite(s);
		// corners pushed past both ends of the coordinate range
		s = base;
		s.restart = 1'b0;
		s.pos_x = 32'h7FFF_FFFF;
		s.pos_y = 32'h8000_0000;
		s.width = 32'h7FFF_FFFF;
		s.height = 32'h8000_0000;
		s.origin_x = 17'd0;
		s.origin_y = 17'd65536;
		send_sprite(s);
		s.angle = 16'd12345;
		send_sprite(s);
		// mirrored sprite, pivot at the far corner
		s = base;
		s.restart = 1'b0;
		s.width = 32'hFFF0_0000;
		s.height = 32'hFFF8_0000;
		s.origin_x = 17'd65536;
		s.origin_y = 17'd65536;
		send_sprite(s);
		for (int n = 0; n < 4; n++) begin
			s = base;
			s.restart = 1'b0;
			s.flips = 2'(n);
			send_sprite(s);
		end
		foreach (DIR_ANGLES[n]) begin
			s = base;
			s.restart = 1'b0;
			s.pos_x = 32'h0040_0000;
			s.pos_y = 32'hFFC0_0000;
			s.origin_x = 17'd131071;
			s.angle = DIR_ANGLES[n];
			send_sprite(s);
		end
		drain();

		// no room at all: everything is dropped, restart or not
		set_capacity(17'd0);
		send_sprite(base);
		s = base;
		s.restart = 1'b0;
		send_sprite(s);
		send_sprite(s);
		drain();

		// exactly one sprite fits per batch
		set_capacity(17'd6);
		send_sprite(base);
		send_sprite(s);
		send_sprite(base);
		drain();

		set_capacity(17'd30);
		random_phase(15);
		drain();
		random_phase(15);
		drain();

		send_idle_pct = 60;
		recv_stall_pct = 10;
		set_capacity(17'($urandom_range(12, 400)));
		random_phase(10);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_capacity(17'd65536);
		random_phase(5);
		drain();

		// register above the ceiling: behaves as a 65536-slot buffer
		set_capacity(17'd131071);
		for (int n = 0; n < CEIL_ITEMS; n++) begin
			s = rand_sprite(0);
			s.restart = (n == 0);
			send_sprite(s);
		end
		drain();

		if (chk_fails == 0) begin
			$display("rotated_sprite_quad_expander test passed");
		end else begin
			$display("rotated_sprite_quad_expander test failed");
		end
		$finish;
	end

endmodule
